### sv/json_string_unescape_utf8_assert.svh
// Assertion macros for the checker file jsu_checker.sv.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define JSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jsu assertion failed");

// Next-cycle implication, checked out of reset.
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jsu assertion failed");

`endif

### sv/jsu_pkg.sv
package jsu_pkg;

  typedef enum logic [1:0] {
    KindValue = 2'd0,
    KindDone  = 2'd1,
    KindError = 2'd2
  } kind_e;

  localparam int unsigned MaxResults = 4;

  // up to four results produced by one source byte
  typedef struct packed {
    logic [MaxResults-1:0][7:0] data;
    kind_e [MaxResults-1:0]     kind;
    logic [1:0]                 cnt_m1;
  } bundle_t;

  // bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    return v;
  endfunction

endpackage

### sv/jsu_decode.sv
module jsu_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output jsu_pkg::bundle_t bundle_o,
  output logic             push_o
);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhString = 2'd1;
  localparam logic [1:0] PhEscape = 2'd2;
  localparam logic [1:0] PhHex    = 2'd3;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChF = 8'h66;
  localparam logic [7:0] ChN = 8'h6E;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChU = 8'h75;

  logic [1:0]  phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] cp_q, cp_d;

  logic [2:0]  n;
  logic        fin;
  logic [4:0]  hv;
  logic [15:0] cp_new;
  logic        esc_ok;
  logic [7:0]  esc_byte;
  jsu_pkg::bundle_t b;

  assign hv     = jsu_pkg::hex_value(byte_i);
  assign cp_new = {cp_q[11:0], hv[3:0]};

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = byte_i;
    case (byte_i)
      ChQuote, ChBslash, ChSlash: esc_byte = byte_i;
      ChB: esc_byte = 8'h08;
      ChF: esc_byte = 8'h0C;
      ChN: esc_byte = 8'h0A;
      ChR: esc_byte = 8'h0D;
      ChT: esc_byte = 8'h09;
      default: begin
        esc_ok   = 1'b0;
        esc_byte = 8'h00;
      end
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    cp_d      = cp_q;
    n         = 3'd0;
    fin       = 1'b0;
    b.data    = '0;
    b.kind    = '{default: jsu_pkg::KindValue};
    case (phase_q)
      PhIdle: begin
        if (byte_i == ChQuote) begin
          phase_d = PhString;
        end else begin
          b.kind[0] = jsu_pkg::KindError;
          n = 3'd1;
          fin = 1'b1;
        end
      end
      PhString: begin
        if (byte_i == ChQuote) begin
          b.kind[0] = jsu_pkg::KindDone;
          n = 3'd1;
          fin = 1'b1;
        end else if (byte_i == ChBslash) begin
          phase_d = PhEscape;
        end else begin
          b.data[0] = byte_i;
          n = 3'd1;
        end
      end
      PhEscape: begin
        if (esc_ok) begin
          b.data[0] = esc_byte;
          n = 3'd1;
          phase_d = PhString;
        end else if (byte_i == ChU) begin
          phase_d   = PhHex;
          hex_cnt_d = 2'd0;
          cp_d      = 16'h0000;
        end else begin
          b.kind[0] = jsu_pkg::KindError;
          n = 3'd1;
          fin = 1'b1;
        end
      end
      PhHex: begin
        if (hv[4]) begin
          b.kind[0] = jsu_pkg::KindError;
          n = 3'd1;
          fin = 1'b1;
        end else if (hex_cnt_q == 2'd3) begin
          if (cp_new <= 16'h007F) begin
            b.data[0] = cp_new[7:0];
            n = 3'd1;
          end else if (cp_new <= 16'h07FF) begin
            b.data[0] = {3'b110, cp_new[10:6]};
            b.data[1] = {2'b10, cp_new[5:0]};
            n = 3'd2;
          end else begin
            b.data[0] = {4'b1110, cp_new[15:12]};
            b.data[1] = {2'b10, cp_new[11:6]};
            b.data[2] = {2'b10, cp_new[5:0]};
            n = 3'd3;
          end
          phase_d   = PhString;
          hex_cnt_d = 2'd0;
          cp_d      = 16'h0000;
        end else begin
          cp_d      = cp_new;
          hex_cnt_d = hex_cnt_q + 2'd1;
        end
      end
      default: phase_d = PhIdle;
    endcase

    if (fin) begin
      phase_d   = PhIdle;
      hex_cnt_d = 2'd0;
      cp_d      = 16'h0000;
    end else if (last_i && phase_d != PhIdle) begin
      // source ran out inside the string
      b.kind[n[1:0]] = jsu_pkg::KindError;
      b.data[n[1:0]] = 8'h00;
      n = n + 3'd1;
      phase_d   = PhIdle;
      hex_cnt_d = 2'd0;
      cp_d      = 16'h0000;
    end
    b.cnt_m1 = 2'(n - 3'd1);
  end

  assign bundle_o = b;
  assign push_o   = (n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      hex_cnt_q <= 2'd0;
      cp_q      <= 16'h0000;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      cp_q      <= cp_d;
    end
  end

endmodule

### sv/jsu_serial.sv
module jsu_serial (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jsu_pkg::bundle_t bundle_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [7:0]       data_o,
  output jsu_pkg::kind_e   kind_o,
  output logic             last_o
);

  logic             out_valid_q;
  jsu_pkg::bundle_t out_q;
  logic [1:0]       idx_q;
  logic             hold_valid_q;
  jsu_pkg::bundle_t hold_q;

  logic pop_done;
  logic out_free;

  assign last_o   = (idx_q == out_q.cnt_m1);
  assign pop_done = out_valid_q && ready_i && last_o;
  assign out_free = !out_valid_q || pop_done;
  assign full_o   = hold_valid_q;
  assign valid_o  = out_valid_q;
  assign data_o   = out_q.data[idx_q];
  assign kind_o   = out_q.kind[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
      idx_q        <= 2'd0;
    end else begin
      if (out_free) begin
        idx_q <= 2'd0;
        if (hold_valid_q) begin
          out_valid_q  <= 1'b1;
          hold_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push_i;
        end
      end else begin
        if (ready_i) idx_q <= idx_q + 2'd1;
        if (push_i) hold_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (hold_valid_q) out_q <= hold_q;
      else if (push_i) out_q <= bundle_i;
    end else if (push_i) begin
      hold_q <= bundle_i;
    end
  end

endmodule

### sv/json_string_unescape_utf8.sv
// JSON string unescaper with UTF-8 output.
// Slave stream: one source byte per word in s_axis_tdata, s_axis_tlast marks
// the last byte of the source. Master stream: one result per word, tdata is
// the decoded byte, tuser the kind (value, string complete, error), tlast the
// last result caused by one source byte.
// The output buffer is registered, so a byte's results appear only after it
// is taken. Throughput is one source byte per cycle while each byte gives at
// most one result and the receiver keeps up; a \u escape can give up to three
// bytes plus an error and these leave one per cycle from the output buffer.
// Bytes that give no result (opening quote, backslash, leading hex digits)
// take no room in the output buffer.
// The output side holds two result groups, so s_axis_tready drops only when
// a second group waits behind one that is still leaving, either because it
// holds several words or because the receiver stalls.
// Reset puts the decoder back to waiting for an opening quote and empties
// the output buffer; results are held unchanged while m_axis_tready is low.
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic [1:0] m_axis_tuser,  // [1:0] kind
  output logic       m_axis_tlast
);

  logic             fire;
  logic             push;
  logic             full;
  jsu_pkg::bundle_t bundle;
  jsu_pkg::kind_e   kind;

  assign s_axis_tready = !full;
  assign fire          = s_axis_tvalid && s_axis_tready;

  jsu_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .bundle_o (bundle),
    .push_o   (push)
  );

  jsu_serial u_serial (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fire && push),
    .bundle_i (bundle),
    .full_o   (full),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .data_o   (m_axis_tdata),
    .kind_o   (kind),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = kind;

endmodule

### sv/jsu_checker.sv
`include "json_string_unescape_utf8_assert.svh"

module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  logic is_value;
  logic is_done;
  logic is_error;

  assign is_value = (m_axis_tuser == jsu_pkg::KindValue);
  assign is_done  = (m_axis_tuser == jsu_pkg::KindDone);
  assign is_error = (m_axis_tuser == jsu_pkg::KindError);

  `JSU_ASSERT_NOW(a_kind_legal, m_axis_tvalid, is_value || is_done || is_error)

  `JSU_ASSERT_NOW(a_status_zero_byte, m_axis_tvalid && !is_value, m_axis_tdata == 8'h00)

  `JSU_ASSERT_NOW(a_status_ends_run, m_axis_tvalid && (is_done || is_error), m_axis_tlast)

  `JSU_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic [7:0] Quote     = 8'h22;
  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] LetterU   = 8'h75;
  localparam int         DirLen    = 25;
  localparam int         RandWords = 405;

  typedef enum logic [1:0] {
    ScanIdle,
    ScanString,
    ScanEscape,
    ScanHex
  } scan_e;

  typedef struct {
    logic [7:0]     b;
    logic           eos;
    bit             typed;
    jsu_pkg::kind_e tkind;
  } src_word_t;

  typedef struct {
    logic [7:0]     data;
    jsu_pkg::kind_e kind;
    logic           last;
  } result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  // typed rows: one result, byte 0, last set
  src_word_t dir_tab [DirLen] = '{
    '{8'h00, 1'b0, 1'b1, jsu_pkg::KindError},
    '{8'hFF, 1'b0, 1'b1, jsu_pkg::KindError},
    '{Quote, 1'b1, 1'b1, jsu_pkg::KindError},
    '{Quote, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{8'h00, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{8'hFF, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{Backslash, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{8'h2F, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{Backslash, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{LetterU, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{8'h66, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{8'h46, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{8'h66, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{8'h61, 1'b1, 1'b0, jsu_pkg::KindValue},
    '{Quote, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{Backslash, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{8'h71, 1'b0, 1'b1, jsu_pkg::KindError},
    '{Quote, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{Backslash, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{LetterU, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{8'h67, 1'b0, 1'b1, jsu_pkg::KindError},
    '{Quote, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{Quote, 1'b0, 1'b1, jsu_pkg::KindDone},
    '{Quote, 1'b0, 1'b0, jsu_pkg::KindValue},
    '{Quote, 1'b1, 1'b1, jsu_pkg::KindDone}
  };

  logic [7:0] esc_tab [8] = '{Quote, Backslash, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};

  src_word_t   src_words[$];
  result_t     fresh[$];
  result_t     decoded_q[$];
  scan_e       scan = ScanIdle;
  logic [1:0]  hex_cnt = 2'd0;
  logic [15:0] cp_acc = 16'h0000;
  int          n_taken = 0;
  int          n_checked = 0;
  int          n_fail = 0;
  int          n_done = 0;
  int          n_err = 0;
  logic [8:0]  rx_cnt = 9'd0;
  result_t     got;
  result_t     want;

  json_string_unescape_utf8 uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .m_axis_tlast (m_tlast)
  );

  always #4 clk_i = ~clk_i;

  function automatic int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  task automatic push_word(input logic [7:0] b, input logic eos);
    src_words.insert(src_words.size(), '{b, eos, 1'b0, jsu_pkg::KindValue});
  endtask

  task automatic put_result(input logic [7:0] data, input jsu_pkg::kind_e kind);
    fresh.insert(fresh.size(), '{data, kind, 1'b0});
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic eos);
    int   d;
    logic ended;
    ended = 1'b0;
    case (scan)
      ScanIdle: begin
        if (c == Quote) scan = ScanString;
        else begin
          put_result(8'h00, jsu_pkg::KindError);
          ended = 1'b1;
        end
      end
      ScanString: begin
        if (c == Quote) begin
          put_result(8'h00, jsu_pkg::KindDone);
          ended = 1'b1;
        end else if (c == Backslash) begin
          scan = ScanEscape;
        end else begin
          put_result(c, jsu_pkg::KindValue);
        end
      end
      ScanEscape: begin
        scan = ScanString;
        case (c)
          Quote, Backslash, 8'h2F: put_result(c, jsu_pkg::KindValue);
          8'h62: put_result(8'h08, jsu_pkg::KindValue);
          8'h66: put_result(8'h0C, jsu_pkg::KindValue);
          8'h6E: put_result(8'h0A, jsu_pkg::KindValue);
          8'h72: put_result(8'h0D, jsu_pkg::KindValue);
          8'h74: put_result(8'h09, jsu_pkg::KindValue);
          LetterU: begin
            scan = ScanHex;
            hex_cnt = 2'd0;
            cp_acc = 16'h0000;
          end
          default: begin
            put_result(8'h00, jsu_pkg::KindError);
            ended = 1'b1;
          end
        endcase
      end
      default: begin
        d = nibble_of(c);
        if (d < 0) begin
          put_result(8'h00, jsu_pkg::KindError);
          ended = 1'b1;
        end else begin
          cp_acc = {cp_acc[11:0], 4'(d)};
          if (hex_cnt == 2'd3) begin
            if (cp_acc <= 16'h007F) begin
              put_result(cp_acc[7:0], jsu_pkg::KindValue);
            end else if (cp_acc <= 16'h07FF) begin
              put_result({3'b110, cp_acc[10:6]}, jsu_pkg::KindValue);
              put_result({2'b10, cp_acc[5:0]}, jsu_pkg::KindValue);
            end else begin
              put_result({4'b1110, cp_acc[15:12]}, jsu_pkg::KindValue);
              put_result({2'b10, cp_acc[11:6]}, jsu_pkg::KindValue);
              put_result({2'b10, cp_acc[5:0]}, jsu_pkg::KindValue);
            end
            scan = ScanString;
            hex_cnt = 2'd0;
            cp_acc = 16'h0000;
          end else begin
            hex_cnt = hex_cnt + 2'd1;
          end
        end
      end
    endcase
    if (!ended && eos && scan != ScanIdle) begin
      put_result(8'h00, jsu_pkg::KindError);
      ended = 1'b1;
    end
    if (ended) begin
      scan = ScanIdle;
      hex_cnt = 2'd0;
      cp_acc = 16'h0000;
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
  endtask

  task automatic note_fail(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // receiver: free running, coin flips, long stalls, mostly ready
  always @(posedge clk_i) begin
    rx_cnt <= rx_cnt + 9'd1;
    case (rx_cnt[8:7])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (rx_cnt[3:0] >= 4'd11);
      default: m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) begin
      fresh.delete();
      decode_byte(s_tdata, s_tlast);
      if (src_words[n_taken].typed) begin
        decoded_q.insert(decoded_q.size(), '{8'h00, src_words[n_taken].tkind, 1'b1});
      end else begin
        foreach (fresh[i]) decoded_q.insert(decoded_q.size(), fresh[i]);
      end
      n_taken++;
    end
    if (rst_ni && m_tvalid && m_tready) begin
      got = '{m_tdata, jsu_pkg::kind_e'(m_tuser), m_tlast};
      if (got.kind == jsu_pkg::KindDone) n_done++;
      if (got.kind == jsu_pkg::KindError) n_err++;
      if (decoded_q.size() == 0) begin
        note_fail($sformatf("unexpected word: byte %02h kind %0d last %0b",
                            m_tdata, m_tuser, m_tlast));
      end else begin
        want = decoded_q.pop_front();
        if (m_tdata !== want.data || m_tuser !== want.kind || m_tlast !== want.last)
          note_fail($sformatf("word %0d: expected byte %02h kind %0d last %0b, got %02h %0d %0b",
                              n_checked, want.data, want.kind, want.last,
                              m_tdata, m_tuser, m_tlast));
        n_checked++;
      end
    end
  end

  initial begin
    logic [7:0]  b;
    logic [15:0] cp;
    int          pick, ntok, sel, cut_at, burst, good;
    bit          broken, cut;

    foreach (dir_tab[i]) src_words.insert(src_words.size(), dir_tab[i]);
    while (src_words.size() < DirLen + RandWords) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        b = 8'($urandom_range(0, 255));
        if (b == Quote) b = 8'h21;
        push_word(b, 1'($urandom_range(0, 1)));
      end else begin
        push_word(Quote, pick < 11);
        if (pick >= 11) begin
          ntok = $urandom_range(0, 8);
          broken = 1'b0;
          for (int t = 0; t < ntok && !broken; t++) begin
            sel = $urandom_range(0, 99);
            cut = ($urandom_range(0, 29) == 0);
            if (sel < 50) begin
              b = 8'($urandom_range(0, 255));
              if (b == Quote || b == Backslash) b = b ^ 8'h01;
              push_word(b, cut);
            end else if (sel < 70) begin
              push_word(Backslash, 1'b0);
              push_word(esc_tab[$urandom_range(0, 7)], cut);
            end else if (sel < 92) begin
              case ($urandom_range(0, 9))
                0: cp = 16'h0000;
                1: cp = 16'hFFFF;
                2: cp = ($urandom_range(0, 1)) ? 16'h007F : 16'h0080;
                3: cp = ($urandom_range(0, 1)) ? 16'h07FF : 16'h0800;
                4, 5: cp = 16'($urandom_range(0, 16'h007F));
                6, 7: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
              endcase
              cut_at = cut ? $urandom_range(0, 3) : 4;
              if (cut && $urandom_range(0, 1)) cut_at = 3;
              push_word(Backslash, 1'b0);
              push_word(LetterU, 1'b0);
              for (int k = 0; k < 4 && k <= cut_at; k++)
                push_word(hex_char(cp[4*(3-k) +: 4]), k == cut_at);
            end else if (sel < 96) begin
              do b = 8'($urandom_range(0, 255));
              while (b inside {Quote, Backslash, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74,
                               LetterU});
              push_word(Backslash, 1'b0);
              push_word(b, 1'b0);
              broken = 1'b1;
            end else begin
              good = $urandom_range(0, 3);
              push_word(Backslash, 1'b0);
              push_word(LetterU, 1'b0);
              for (int k = 0; k < good; k++) push_word(hex_char(4'($urandom_range(0, 15))), 1'b0);
              do b = 8'($urandom_range(0, 255));
              while (nibble_of(b) >= 0);
              push_word(b, 1'b0);
              broken = 1'b1;
            end
            if (cut) broken = 1'b1;
          end
          if (!broken) push_word(Quote, $urandom_range(0, 9) == 0);
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst = 0;
    foreach (src_words[i]) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
      burst--;
      s_tvalid <= 1'b1;
      s_tdata  <= src_words[i].b;
      s_tlast  <= src_words[i].eos;
      @(posedge clk_i);
      while (!s_tready) @(posedge clk_i);
    end
    s_tvalid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d source words sent, %0d result words checked", n_taken, n_checked);
    $display("%0d strings completed, %0d error reports", n_done, n_err);
    if (n_fail == 0 && decoded_q.size() == 0) begin
      $display("json_string_unescape_utf8 verification clean");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("json_string_unescape_utf8 verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("json_string_unescape_utf8 verification failed");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/jsu_pkg.sv
sv/jsu_decode.sv
sv/jsu_serial.sv
sv/json_string_unescape_utf8.sv
sv/jsu_checker.sv
dv/tb.sv
